/* hdl/csfr_pkg.sv */
// ----------------------------------------------------------------------------
// csfr_pkg
// Shared types and constants of the character-stuffed frame receiver.
// ----------------------------------------------------------------------------
package csfr_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 3;

    // Stuffing text "DLE DLE "
    localparam logic [7:0] STUFF_PAT [WIN_DEPTH] = '{
        8'h44, 8'h4C, 8'h45, 8'h20, 8'h44, 8'h4C, 8'h45, 8'h20
    };

    localparam logic [7:0] SYNC_RST = 8'd22;
    localparam logic [7:0] SOH_RST  = 8'd1;
    localparam logic [7:0] STX_RST  = 8'd2;
    localparam logic [7:0] ETX_RST  = 8'd3;

    localparam logic [1:0] REG_SYNC = 2'd0;
    localparam logic [1:0] REG_SOH  = 2'd1;
    localparam logic [1:0] REG_STX  = 2'd2;
    localparam logic [1:0] REG_ETX  = 2'd3;

    localparam logic [1:0] KIND_HEAD  = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
        logic [7:0] data;
    } t_win_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       front;
        logic             match_full;
        logic             match_group;
    } t_win_stat;

    typedef struct packed {
        logic       emit;
        logic       fin;
        logic [7:0] data;
        logic [1:0] kind;
    } t_res_req;

endpackage

/* hdl/csfr_if.sv */
// ----------------------------------------------------------------------------
// csfr_in_if / csfr_out_if
// Valid/ready channels for received bytes and result beats.
// ----------------------------------------------------------------------------
interface csfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_stream;

    modport source (output valid, output rx_byte, output end_of_stream, input ready);
    modport sink   (input valid, input rx_byte, input end_of_stream, output ready);
endinterface

interface csfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

/* hdl/char_stuffed_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// char_stuffed_frame_receiver_top
// Bisync-style deframer: sync hunt, header pass, DLE de-stuffing of data,
// check byte capture, sequenced one window step per cycle.
//
//   port      dir  beat payload
//   i_in      in   rx_byte[7:0], end_of_stream
//   o_out     out  out_byte[7:0], kind[1:0], last
//   i_cfg_*   in   write enable, index[1:0], data[7:0] (no handshake)
//
// An item passes accept, decode, end check and finish. A data byte adds
// a window check and, unless it still fits a skipped group, a drain that
// releases held bytes and emits the stuffing text for a stuffed group.
// End of text adds a flush of the held bytes; end of stream adds a flush
// and a second end check.
// Synchronous active-low reset; window contents are not cleared.
// i_in.ready is high only between items. Output stalls hold the sequencer.
// ----------------------------------------------------------------------------
module char_stuffed_frame_receiver_top
    import csfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    csfr_in_if.sink    i_in,
    csfr_out_if.source o_out
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_HEAD, PH_DATA, PH_CHECK, PH_IGNORE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE, S_EVAL, S_FEED, S_DRAIN, S_GROUP, S_FLUSH, S_EOS, S_END
    } t_state;

    logic [7:0] r_sync, r_soh, r_stx, r_etx;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic       r_skip,  n_skip;
    logic [1:0] r_gcnt,  n_gcnt;
    logic [7:0] r_byte,  n_byte;
    logic       r_eos,   n_eos;

    t_win_cmd   w_cmd;
    t_win_stat  w_stat;
    t_res_req   w_req;
    logic       w_grant;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RST;
            r_soh  <= SOH_RST;
            r_stx  <= STX_RST;
            r_etx  <= ETX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SYNC: r_sync <= i_cfg_data;
                REG_SOH:  r_soh  <= i_cfg_data;
                REG_STX:  r_stx  <= i_cfg_data;
                REG_ETX:  r_etx  <= i_cfg_data;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_skip  = r_skip;
        n_gcnt  = r_gcnt;
        n_byte  = r_byte;
        n_eos   = r_eos;
        w_cmd   = '0;
        w_req   = '0;
        w_cmd.data = r_byte;
        w_req.data = r_byte;
        w_req.kind = KIND_DATA;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_byte  = i_in.rx_byte;
                    n_eos   = i_in.end_of_stream;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_EOS;
                unique case (r_phase)
                    PH_HUNT: begin
                        if (r_byte == r_sync) begin
                            n_phase = PH_HUNT;
                        end else if (r_byte == r_soh) begin
                            n_phase = PH_HEAD;
                        end else if (r_byte == r_stx) begin
                            n_phase = PH_DATA;
                        end else begin
                            w_req.emit = 1'b1;
                            w_req.kind = KIND_HEAD;
                            n_phase    = PH_HEAD;
                        end
                    end
                    PH_HEAD: begin
                        if (r_byte == r_stx) begin
                            n_phase = PH_DATA;
                        end else begin
                            w_req.emit = 1'b1;
                            w_req.kind = KIND_HEAD;
                        end
                    end
                    PH_DATA: begin
                        if (r_byte == r_etx) begin
                            n_phase = PH_CHECK;
                            n_state = S_FLUSH;
                        end else begin
                            w_cmd.push = 1'b1;
                            n_state    = S_FEED;
                        end
                    end
                    PH_CHECK: begin
                        w_req.emit = 1'b1;
                        w_req.kind = KIND_CHECK;
                        n_phase    = PH_IGNORE;
                    end
                    default: begin
                        n_phase = PH_IGNORE;
                    end
                endcase
            end
            S_FEED: begin
                if (r_skip && w_stat.match_group) begin
                    if (w_stat.count >= CNT_W'(4)) w_cmd.clear = 1'b1;
                    n_state = S_EOS;
                end else begin
                    n_skip  = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_stat.count != '0 && !w_stat.match_full) begin
                    w_req.emit = 1'b1;
                    w_req.data = w_stat.front;
                    w_cmd.pop  = 1'b1;
                end else if (w_stat.count == CNT_W'(WIN_DEPTH)) begin
                    n_gcnt  = '0;
                    n_state = S_GROUP;
                end else begin
                    n_state = S_EOS;
                end
            end
            S_GROUP: begin
                w_req.emit = 1'b1;
                w_req.data = STUFF_PAT[{1'b0, r_gcnt}];
                n_gcnt     = r_gcnt + 2'd1;
                if (r_gcnt == 2'd3) begin
                    w_cmd.clear = 1'b1;
                    n_skip      = 1'b1;
                    n_state     = S_EOS;
                end
            end
            S_FLUSH: begin
                if (w_stat.count != '0) begin
                    w_req.emit = 1'b1;
                    w_req.data = w_stat.front;
                    w_cmd.pop  = 1'b1;
                end else begin
                    n_skip  = 1'b0;
                    n_state = S_EOS;
                end
            end
            S_EOS: begin
                if (r_eos) begin
                    n_phase = PH_HUNT;
                    n_eos   = 1'b0;
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                w_req.fin = 1'b1;
                n_state   = S_IDLE;
            end
        endcase

        if ((w_req.emit || w_req.fin) && !w_grant) begin
            n_state = r_state;
            n_phase = r_phase;
            n_skip  = r_skip;
            n_gcnt  = r_gcnt;
            n_eos   = r_eos;
            w_cmd.push  = 1'b0;
            w_cmd.pop   = 1'b0;
            w_cmd.clear = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HUNT;
            r_skip  <= 1'b0;
            r_gcnt  <= '0;
            r_eos   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_skip  <= n_skip;
            r_gcnt  <= n_gcnt;
            r_eos   <= n_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    csfr_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    csfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_grant (w_grant),
        .o_out   (o_out)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready held after accepted beat");

    a_group_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GROUP) |-> (w_stat.count == CNT_W'(WIN_DEPTH)))
        else $error("group emit without full window");

    a_skip_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_skip) |-> (w_stat.count < CNT_W'(4)))
        else $error("skipping with long window");

    a_idle_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_phase != PH_DATA) |-> (w_stat.count == '0))
        else $error("window held outside data phase");

endmodule

/* hdl/csfr_window.sv */
// ----------------------------------------------------------------------------
// csfr_window
// Eight-byte hold window with push, pop-front and clear, and the shared
// pattern compare against the stuffing text.
// ----------------------------------------------------------------------------
module csfr_window
    import csfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_win_cmd  i_cmd,
    output t_win_stat o_stat
);

    logic [7:0]       r_win [WIN_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic             w_bad_full;
    logic             w_bad_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win[r_cnt[IDX_W-1:0]] <= i_cmd.data;
        end else if (i_cmd.pop) begin
            for (int k = 1; k < WIN_DEPTH; k++) begin
                r_win[k-1] <= r_win[k];
            end
        end
    end

    always_comb begin
        w_bad_full  = 1'b0;
        w_bad_group = 1'b0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            if (CNT_W'(k) < r_cnt) begin
                if (r_win[k] != STUFF_PAT[k]) w_bad_full = 1'b1;
                if (r_win[k] != STUFF_PAT[k % 4]) w_bad_group = 1'b1;
            end
        end
    end

    assign o_stat.count       = r_cnt;
    assign o_stat.front       = r_win[0];
    assign o_stat.match_full  = !w_bad_full;
    assign o_stat.match_group = !w_bad_group;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WIN_DEPTH))
        else $error("window count out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_cnt < CNT_W'(WIN_DEPTH))
        else $error("push into full window");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_cnt != '0)
        else $error("pop from empty window");

endmodule

/* hdl/csfr_out_stage.sv */
// ----------------------------------------------------------------------------
// csfr_out_stage
// Holds one pending result until the next one or the end of the item is
// known, which settles last, then registers it onto the output channel.
// ----------------------------------------------------------------------------
module csfr_out_stage
    import csfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_res_req   i_req,
    output logic       o_grant,
    csfr_out_if.source o_out
);

    logic       r_o_valid;
    logic [7:0] r_o_byte;
    logic [1:0] r_o_kind;
    logic       r_o_last;
    logic       r_p_valid;
    logic [7:0] r_p_byte;
    logic [1:0] r_p_kind;
    logic       w_can_push;
    logic       w_push;

    assign w_can_push = !r_o_valid || o_out.ready;
    assign o_grant    = !r_p_valid || w_can_push;
    assign w_push     = o_grant && r_p_valid && (i_req.emit || i_req.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            if (o_grant && i_req.emit) begin
                r_p_valid <= 1'b1;
            end else if (o_grant && i_req.fin) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_byte <= r_p_byte;
            r_o_kind <= r_p_kind;
            r_o_last <= i_req.fin;
        end
        if (o_grant && i_req.emit) begin
            r_p_byte <= i_req.data;
            r_p_kind <= i_req.kind;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.out_byte = r_o_byte;
    assign o_out.kind     = r_o_kind;
    assign o_out.last     = r_o_last;

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && o_out.ready && !r_o_last) |-> r_p_valid)
        else $error("non-last beat delivered with nothing pending");

    a_single_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.emit && i_req.fin))
        else $error("emit and finish requested together");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready) |=> r_o_valid)
        else $error("output beat dropped while stalled");

endmodule

/* test/char_stuffed_frame_receiver_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_stuffed_frame_receiver_top_tb
// Drives received bytes into the deframer and scores every output beat
// against an in-bench model of sync hunt, header pass, DLE de-stuffing and
// check byte capture, across several code settings and flow-control mixes.
// ----------------------------------------------------------------------------
module char_stuffed_frame_receiver_top_tb;
    import csfr_pkg::*;

    localparam int STUCK_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLDOFF_LEN   = 200;
    localparam int PHASE_ITEMS   = 48;

    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_SP = 8'h20;

    typedef enum logic [2:0] {
        PH_HUNT, PH_HEAD, PH_DATA, PH_CHECK, PH_IGNORE
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_deframed_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    csfr_in_if  in_ch ();
    csfr_out_if out_ch ();

    char_stuffed_frame_receiver_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // model state
    logic [7:0]     cfg_sync, cfg_soh, cfg_stx, cfg_etx;
    t_rx_phase      rx_phase;
    logic [7:0]     win_bytes [WIN_DEPTH];
    int             win_cnt;
    bit             skip_groups;
    t_deframed_beat step_beats [$];
    t_deframed_beat expected_beats [$];

    int err_count      = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int stuck_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want_v);
        if (err_count < 100)
            $display("%0t: %s mismatch, got %02h want %02h", $time, what, got, want_v);
        err_count++;
    endtask

    function automatic void emit_beat(input logic [7:0] b, input logic [1:0] k);
        t_deframed_beat bt;
        if (step_beats.size() >= WIN_DEPTH)
            return;
        bt.data = b;
        bt.kind = k;
        bt.last = 1'b0;
        step_beats.push_back(bt);
    endfunction

    function automatic void pop_held();
        if (win_cnt == 0)
            return;
        emit_beat(win_bytes[0], KIND_DATA);
        for (int k = 1; k < win_cnt; k++)
            win_bytes[k-1] = win_bytes[k];
        win_cnt--;
    endfunction

    function automatic bit held_match(input bit group_only);
        logic [7:0] want_b;
        for (int k = 0; k < win_cnt && k < WIN_DEPTH; k++) begin
            want_b = group_only ? STUFF_PAT[k % 4] : STUFF_PAT[k];
            if (win_bytes[k] != want_b)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void drain_held();
        while (win_cnt > 0 && !held_match(1'b0))
            pop_held();
        if (win_cnt >= WIN_DEPTH) begin
            for (int k = 0; k < 4; k++)
                emit_beat(STUFF_PAT[k], KIND_DATA);
            win_cnt = 0;
            skip_groups = 1'b1;
        end
    endfunction

    function automatic void take_data(input logic [7:0] b);
        if (win_cnt >= WIN_DEPTH)
            pop_held();
        win_bytes[win_cnt] = b;
        win_cnt++;
        if (skip_groups) begin
            if (held_match(1'b1)) begin
                if (win_cnt >= 4)
                    win_cnt = 0;
                return;
            end
            skip_groups = 1'b0;
        end
        drain_held();
    endfunction

    function automatic void flush_held();
        while (win_cnt > 0)
            pop_held();
        skip_groups = 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic eos);
        step_beats.delete();
        case (rx_phase)
            PH_HUNT: begin
                if (b == cfg_sync) begin
                end else if (b == cfg_soh) begin
                    rx_phase = PH_HEAD;
                end else if (b == cfg_stx) begin
                    rx_phase = PH_DATA;
                end else begin
                    emit_beat(b, KIND_HEAD);
                    rx_phase = PH_HEAD;
                end
            end
            PH_HEAD: begin
                if (b == cfg_stx)
                    rx_phase = PH_DATA;
                else
                    emit_beat(b, KIND_HEAD);
            end
            PH_DATA: begin
                if (b == cfg_etx) begin
                    flush_held();
                    rx_phase = PH_CHECK;
                end else begin
                    take_data(b);
                end
            end
            PH_CHECK: begin
                emit_beat(b, KIND_CHECK);
                rx_phase = PH_IGNORE;
            end
            default: rx_phase = PH_IGNORE;
        endcase
        if (eos) begin
            flush_held();
            rx_phase = PH_HUNT;
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[k])
            expected_beats.push_back(step_beats[k]);
    endfunction

    // call at a rising edge; returns at the edge that accepts the beat
    task automatic send_beat(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= b;
        in_ch.end_of_stream <= eos;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        deframe_byte(b, eos);
        items_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_codes(input logic [7:0] sync_v, input logic [7:0] soh_v,
                               input logic [7:0] stx_v, input logic [7:0] etx_v);
        logic [1:0] regs [4] = '{REG_SYNC, REG_SOH, REG_STX, REG_ETX};
        logic [7:0] vals [4];
        vals = '{sync_v, soh_v, stx_v, etx_v};
        wait_idle();
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_sync = sync_v;
        cfg_soh  = soh_v;
        cfg_stx  = stx_v;
        cfg_etx  = etx_v;
    endtask

    function automatic logic [7:0] pick_byte(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == avoid)
            b = ~avoid;
        return b;
    endfunction

    task automatic send_frame();
        logic [7:0] fb [$];
        int n, n_part;
        repeat ($urandom_range(0, 2)) fb.push_back(cfg_sync);
        if ($urandom_range(0, 1) == 1)
            fb.push_back(cfg_soh);
        repeat ($urandom_range(0, 3)) fb.push_back(pick_byte(cfg_stx));
        fb.push_back(cfg_stx);
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(0, 3))
                0: begin
                    repeat ($urandom_range(1, 3))
                        for (int k = 0; k < 4; k++)
                            fb.push_back(STUFF_PAT[k]);
                end
                1: begin
                    n_part = $urandom_range(1, 3);
                    for (int k = 0; k < n_part; k++)
                        fb.push_back(STUFF_PAT[k]);
                end
                default: fb.push_back(pick_byte(cfg_etx));
            endcase
        end
        fb.push_back(cfg_etx);
        fb.push_back(8'($urandom));
        repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom));
        n = fb.size();
        // stream cut short somewhere in the frame
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(1, n);
        for (int k = 0; k < n; k++)
            send_beat(fb[k], k == n - 1);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            send_beat(8'($urandom), (k == n - 1) || ($urandom_range(0, 7) == 0));
    endtask

    task automatic test_stuffed_frame();
        logic [7:0] seq [22];
        seq = '{SYNC_RST, SOH_RST, 8'hFF, STX_RST,
                CH_D, CH_L, CH_E, CH_SP, CH_D, CH_L, CH_E, CH_SP,
                CH_D, CH_L, CH_E, CH_SP, CH_D, CH_L, 8'h00,
                ETX_RST, 8'hA5, 8'h5A};
        foreach (seq[k])
            send_beat(seq[k], k == 21);
    endtask

    task automatic test_bare_header_tail();
        logic [7:0] seq [5];
        seq = '{8'h00, STX_RST, CH_D, CH_L, CH_E};
        foreach (seq[k])
            send_beat(seq[k], k == 4);
    endtask

    task automatic test_traffic(input int send_pct, input int recv_pct);
        int start;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                send_frame();
        end
    endtask

    task automatic test_output_holdoff();
        int start;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLDOFF_LEN;
        start = items_sent;
        while (items_sent - start < 30)
            send_frame();
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        send_frame();
        wait_idle();
        send_frame();
        send_frame();
    endtask

    // output side: score accepted beats, drive ready
    initial begin : result_sink
        t_deframed_beat want;
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", out_ch.out_byte, 8'h00);
                end else begin
                    want = expected_beats.pop_front();
                    if (out_ch.out_byte !== want.data)
                        report_mismatch("out_byte", out_ch.out_byte, want.data);
                    if (out_ch.kind !== want.kind)
                        report_mismatch("kind", {6'd0, out_ch.kind}, {6'd0, want.kind});
                    if (out_ch.last !== want.last)
                        report_mismatch("last", {7'd0, out_ch.last}, {7'd0, want.last});
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= REG_SYNC;
        i_cfg_data          <= 8'h00;
        in_ch.valid         <= 1'b0;
        in_ch.rx_byte       <= 8'h00;
        in_ch.end_of_stream <= 1'b0;
        cfg_sync    = SYNC_RST;
        cfg_soh     = SOH_RST;
        cfg_stx     = STX_RST;
        cfg_etx     = ETX_RST;
        rx_phase    = PH_HUNT;
        win_cnt     = 0;
        skip_groups = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stuffed_frame();
        test_bare_header_tail();

        apply_codes(8'hFF, 8'h00, 8'h80, 8'h7F);
        test_traffic(0, 0);
        apply_codes(8'h00, 8'hFF, 8'h7F, 8'h80);
        test_traffic(65, 0);
        // sync equals SOH, STX equals ETX
        apply_codes(8'h55, 8'h55, 8'hAA, 8'hAA);
        test_traffic(0, 65);
        apply_codes(SYNC_RST, SOH_RST, STX_RST, ETX_RST);
        test_traffic(25, 25);

        test_output_holdoff();
        test_drain_pause();

        wait_idle();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
